// ===== sv/ihs_pkg.sv =====
// shared types and constants for the interval history statistics block
// no dependencies; imported by every module of the block
package ihs_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int WIN_W         = 5;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CMP_W         = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int SUM_W         = DATA_W + WIN_W;
  localparam int STEP_W        = $clog2(SUM_W);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_t             command;
    logic [WIN_W-1:0] window_size;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] mean_interval;
    logic [DATA_W-1:0] max_interval;
    logic [DATA_W-1:0] min_interval;
    logic [WIN_W-1:0]  used_count;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== sv/ihs_cell.sv =====
// one history cell: holds a single interval and takes its neighbor's value on shift
// depends on ihs_pkg
module ihs_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [ihs_pkg::DATA_W-1:0] d,
  output logic [ihs_pkg::DATA_W-1:0] q
);
  import ihs_pkg::*;

  logic [DATA_W-1:0] value_r;

  // payload only, no reset: entries are valid below the stored count
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= d;
    end
  end

  assign q = value_r;

endmodule

// ===== sv/ihs_divider.sv =====
// bit-serial restoring divider for the window mean, one quotient bit per cycle
// depends on ihs_pkg
module ihs_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ihs_pkg::SUM_W-1:0]  dividend,
  input  logic [ihs_pkg::WIN_W-1:0]  divisor,
  output ihs_pkg::div_status_t       status,
  output logic [ihs_pkg::SUM_W-1:0]  quotient
);
  import ihs_pkg::*;

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WIN_W:0]    trial;
  logic [WIN_W:0]    diff;

  always_comb begin
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = STEP_W'(SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[WIN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== sv/interval_history_statistics.sv =====
// interval history statistics: tick, mark and reset words are taken without a stall and give no result.
// a query word holds in_stall through the scan state (the cell chain rotates once
// past its tap), the start state, the divider (skipped for an empty window) and the output state.
// the result register lets new words in while it waits.
// rst_n (synchronous) clears count, running flag, elapsed counter and control; the
// history cells are not reset.
module interval_history_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ihs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ihs_pkg::out_word_t out_data
);
  import ihs_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              running_r, running_nxt;
  logic [DATA_W-1:0] elapsed_r, elapsed_nxt;
  logic [WIN_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] max_r, max_nxt;
  logic [DATA_W-1:0] min_r, min_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic              in_accept;
  logic              push;
  logic              shift_en;
  logic              div_start;
  logic              in_window;
  logic [WIN_W-1:0]  used_q;
  logic [DATA_W-1:0] tap;
  logic [DATA_W-1:0] chain_d [HISTORY_DEPTH];
  logic [DATA_W-1:0] chain_q [HISTORY_DEPTH];
  div_status_t       div_status;
  logic [SUM_W-1:0]  quotient;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign push      = in_accept && (in_data.command == CMD_MARK) && running_r;
  assign shift_en  = push || (state_r == S_SCAN);
  assign tap       = chain_q[HISTORY_DEPTH-1];

  // head cell takes a new interval on push, the tail value while scanning (rotation)
  always_comb begin
    chain_d[0] = (state_r == S_SCAN) ? tap : elapsed_r;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      chain_d[i] = chain_q[i-1];
    end
  end

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    ihs_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (chain_d[g]),
      .q        (chain_q[g])
    );
  end

  ihs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (used_r),
    .status   (div_status),
    .quotient (quotient)
  );

  assign used_q = (CMP_W'(in_data.window_size) < CMP_W'(count_r)) ?
                  in_data.window_size : WIN_W'(count_r);

  // at scan step k the tail holds entry (DEPTH-1-k); the newest used entries come last
  assign in_window = (CMP_W'(k_r) + CMP_W'(used_r)) >= CMP_W'(HISTORY_DEPTH);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    running_nxt   = running_r;
    elapsed_nxt   = elapsed_r;
    used_nxt      = used_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.command)
            CMD_TICK: begin
              if (running_r && (elapsed_r != '1)) begin
                elapsed_nxt = elapsed_r + 1'b1;
              end
            end
            CMD_MARK: begin
              if (running_r) begin
                if (count_r != CNT_W'(HISTORY_DEPTH)) begin
                  count_nxt = count_r + 1'b1;
                end
              end else begin
                running_nxt = 1'b1;
                count_nxt   = '0;
              end
              elapsed_nxt = '0;
            end
            CMD_RESET: begin
              count_nxt   = '0;
              running_nxt = 1'b0;
            end
            CMD_QUERY: begin
              used_nxt  = used_q;
              k_nxt     = '0;
              sum_nxt   = '0;
              max_nxt   = '0;
              min_nxt   = '1;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (in_window) begin
          sum_nxt = sum_r + SUM_W'(tap);
          if (tap > max_r) max_nxt = tap;
          if (tap < min_r) min_nxt = tap;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == IDX_W'(HISTORY_DEPTH - 1)) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (used_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.mean_interval = (used_r == '0) ? '0 : quotient[DATA_W-1:0];
          out_data_nxt.max_interval  = max_r;
          out_data_nxt.min_interval  = min_r;
          out_data_nxt.used_count    = used_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      running_r   <= running_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    used_r     <= used_nxt;
    sum_r      <= sum_nxt;
    max_r      <= max_nxt;
    min_r      <= min_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH))
    else $error("stored count above history depth");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CMP_W'(used_r) <= CMP_W'(count_r)))
    else $error("window used count exceeds stored count");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.used_count != '0)) |->
      ((out_data.max_interval >= out_data.min_interval) &&
       (out_data.mean_interval <= out_data.max_interval)))
    else $error("window statistics out of order");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.used_count == '0)) |->
      ((out_data.mean_interval == '0) && (out_data.max_interval == '0) &&
       (out_data.min_interval == '1)))
    else $error("empty window result wrong");

endmodule
